// ----- hdl/stcc_pkg.sv -----
// Shared types and constants for the stacking conveyor count control.
// Holds zone state codes, motor command codes, timing limits and the window test.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stcc_pkg;

    typedef logic [30:0] time_ms_t;
    typedef logic [17:0] span_t;
    typedef logic [2:0]  zone_t;
    typedef logic [1:0]  cmd_t;

    localparam zone_t ZS_UNKNOWN     = 3'd0;
    localparam zone_t ZS_FREE        = 3'd1;
    localparam zone_t ZS_BUSY        = 3'd2;
    localparam zone_t ZS_STACK_READY = 3'd3;
    localparam zone_t ZS_ERROR       = 3'd4;

    localparam cmd_t CMD_NONE = 2'd0;
    localparam cmd_t CMD_FWD  = 2'd1;
    localparam cmd_t CMD_STOP = 2'd2;

    localparam logic [1:0] CFG_PASS_TIME    = 2'd0;
    localparam logic [1:0] CFG_STACK_TARGET = 2'd1;

    localparam span_t    JAM_TIMEOUT_MS  = 18'd90000;
    localparam time_ms_t TIME_CEILING_MS = 31'd99000;

    localparam logic [16:0] PASS_TIME_RESET    = 17'd1000;
    localparam logic [7:0]  STACK_TARGET_RESET = 8'd4;
    localparam span_t       LONG_SPAN_RESET    = 18'd1200;

    // floor(x / 5) = (x * ceil(2^22 / 5)) >> 22, exact for x below 2^20
    localparam logic [19:0] DIV5_RECIP = 20'd838861;
    localparam int          DIV5_SHIFT = 22;

    // True once more than span ms and at most the ceiling have passed since start.
    // An idle timer (zero) or a clock that went backwards never passes.
    function automatic logic win_passed(time_ms_t start, time_ms_t now, span_t span);
        time_ms_t delta;
        delta = now - start;
        return (start != '0) && (start < now) && (delta > 31'(span))
               && (delta <= TIME_CEILING_MS);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/stacking_conveyor_count_control.sv -----
// Stacking conveyor count control: zone state machine, exit counting and belt timers.
// Pipeline: input register and result register, with the state update between the two.
// Throughput: one transaction per cycle unless m_ready holds back the result.
// Reset (aresetn low, synchronous): zone unknown, timer idle, count and flags cleared,
// pass time 1000 ms, stack target 4; both pipeline stages empty.
// Depends on stcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stacking_conveyor_count_control (
    input  wire                     aclk,
    input  wire                     aresetn,
    // configuration write channel
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  [7:0]              cfg_index,
    input  wire  [16:0]             cfg_data,
    // scan tick input channel
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire  [30:0]             s_now_ms,
    input  wire                     s_enter_sensor,
    input  wire                     s_exit_sensor,
    input  wire                     s_entry_pushed,
    input  wire                     s_drive_ready,
    input  wire                     s_product_taken,
    input  wire                     s_reset_request,
    // result channel
    output logic                    m_valid,
    input  wire                     m_ready,
    output stcc_pkg::cmd_t          m_motor_command,
    output stcc_pkg::zone_t         m_zone_state,
    output logic [7:0]              m_product_count,
    output logic                    m_ready_to_receive
);

    import stcc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. The long window floor(pass*6/5) is formed
    // at write time with a reciprocal multiply, so the tick path sees a
    // plain register.
    // ------------------------------------------------------------------
    logic [16:0] pass_time_reg;
    span_t       long_span_reg;
    logic [7:0]  stack_target_reg;

    logic [19:0] pass_x6;
    logic [39:0] div5_prod;
    logic        cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign pass_x6   = 20'(cfg_data) * 20'd6;
    assign div5_prod = 40'(pass_x6) * 40'(DIV5_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_time_reg    <= PASS_TIME_RESET;
            long_span_reg    <= LONG_SPAN_RESET;
            stack_target_reg <= STACK_TARGET_RESET;
        end else if (cfg_fire) begin
            if (cfg_index == 8'(CFG_PASS_TIME)) begin
                pass_time_reg <= cfg_data;
                long_span_reg <= div5_prod[DIV5_SHIFT +: 18];
            end else if (cfg_index == 8'(CFG_STACK_TARGET)) begin
                stack_target_reg <= cfg_data[7:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register: hold one scan tick; advance when the compute stage
    // can push its result into the output register.
    // ------------------------------------------------------------------
    logic     in_valid_reg;
    time_ms_t in_now_reg;
    logic     in_enter_reg;
    logic     in_exit_reg;
    logic     in_drive_reg;
    logic     in_taken_reg;
    logic     in_rst_reg;

    logic     step_fire;

    assign step_fire = in_valid_reg & (~m_valid | m_ready);
    assign s_ready   = ~in_valid_reg | step_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_now_reg   <= s_now_ms;
            // an upstream push counts as the entry sensor for this tick
            in_enter_reg <= s_enter_sensor | s_entry_pushed;
            in_exit_reg  <= s_exit_sensor;
            in_drive_reg <= s_drive_ready;
            in_taken_reg <= s_product_taken;
            in_rst_reg   <= s_reset_request;
        end
    end

    // ------------------------------------------------------------------
    // Zone state.
    // ------------------------------------------------------------------
    zone_t    zone_reg, zone_next;
    time_ms_t run_start_reg, run_start_next;
    logic [7:0] count_reg, count_next;
    logic     exit_seen_reg, exit_seen_next;
    logic     stack_complete_reg, stack_complete_next;
    logic     taken_latch_reg, taken_latch_next;
    cmd_t     cmd_next;
    logic     rtr_next;

    always_comb begin
        zone_next           = zone_reg;
        run_start_next      = run_start_reg;
        count_next          = count_reg;
        exit_seen_next      = exit_seen_reg;
        stack_complete_next = stack_complete_reg;
        taken_latch_next    = taken_latch_reg | in_taken_reg;
        cmd_next            = CMD_NONE;

        // Count rising levels of the exit sensor while the drive is ready;
        // an overcount drops straight to error before the state machine runs.
        if (in_drive_reg) begin
            if (in_exit_reg) begin
                if (!exit_seen_reg) begin
                    if (count_reg != 8'hFF) begin
                        count_next = count_reg + 8'd1;
                    end
                    exit_seen_next = 1'b1;
                end
            end else begin
                exit_seen_next = 1'b0;
            end
            if (count_next > stack_target_reg) begin
                zone_next = ZS_ERROR;
            end
        end

        case (zone_next)
            ZS_UNKNOWN: begin
                if (in_enter_reg || in_exit_reg) begin
                    if (run_start_reg != '0) begin
                        cmd_next       = CMD_STOP;
                        run_start_next = '0;
                    end else begin
                        run_start_next = in_now_reg;
                        cmd_next       = CMD_FWD;
                        zone_next      = ZS_FREE;
                    end
                end
            end
            ZS_FREE: begin
                if (in_enter_reg) begin
                    run_start_next = in_now_reg;
                    cmd_next       = CMD_FWD;
                end
                if (win_passed(run_start_next, in_now_reg, JAM_TIMEOUT_MS)) begin
                    cmd_next  = CMD_STOP;
                    zone_next = ZS_ERROR;
                end
                // a full stack wins over a jam in the same tick
                if (count_next == stack_target_reg) begin
                    zone_next           = ZS_BUSY;
                    run_start_next      = '0;
                    stack_complete_next = 1'b1;
                end else if (win_passed(run_start_next, in_now_reg,
                                        18'(pass_time_reg))) begin
                    cmd_next       = CMD_STOP;
                    run_start_next = '0;
                end
            end
            ZS_BUSY: begin
                if (run_start_reg == '0) begin
                    run_start_next = in_now_reg;
                    cmd_next       = CMD_FWD;
                end
                if (win_passed(run_start_next, in_now_reg, long_span_reg)) begin
                    cmd_next = CMD_STOP;
                end
                if (stack_complete_reg) begin
                    taken_latch_next = 1'b0;
                    zone_next        = ZS_STACK_READY;
                end
                stack_complete_next = 1'b0;
            end
            ZS_STACK_READY: begin
                if (taken_latch_next) begin
                    count_next       = '0;
                    taken_latch_next = 1'b0;
                    zone_next        = ZS_FREE;
                end
                if (win_passed(run_start_reg, in_now_reg, long_span_reg)) begin
                    cmd_next = CMD_STOP;
                end
            end
            ZS_ERROR: begin
                cmd_next = CMD_STOP;
                if (in_rst_reg) begin
                    count_next = '0;
                    zone_next  = ZS_UNKNOWN;
                end
            end
            default: begin
            end
        endcase

        rtr_next = (zone_next == ZS_FREE) && (count_next < stack_target_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg           <= ZS_UNKNOWN;
            run_start_reg      <= '0;
            count_reg          <= '0;
            exit_seen_reg      <= 1'b0;
            stack_complete_reg <= 1'b0;
            taken_latch_reg    <= 1'b0;
        end else if (step_fire) begin
            zone_reg           <= zone_next;
            run_start_reg      <= run_start_next;
            count_reg          <= count_next;
            exit_seen_reg      <= exit_seen_next;
            stack_complete_reg <= stack_complete_next;
            taken_latch_reg    <= taken_latch_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold the result until the transaction completes.
    // ------------------------------------------------------------------
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            m_motor_command    <= cmd_next;
            m_zone_state       <= zone_next;
            m_product_count    <= count_next;
            m_ready_to_receive <= rtr_next;
        end
    end

    assign m_valid = m_valid_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_rtr_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready_to_receive |-> m_zone_state == ZS_FREE)
        else $error("ready_to_receive outside free state");

    a_error_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_zone_state == ZS_ERROR) |-> m_motor_command == CMD_STOP)
        else $error("error state without stop command");

    a_stack_flag_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        zone_reg == ZS_STACK_READY |-> !stack_complete_reg)
        else $error("stack complete flag left set in stack ready");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid && !m_ready)
        else $error("input stalled without a blocked result");

    a_step_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire |=> m_valid)
        else $error("computed tick did not reach the result register");

endmodule

`default_nettype wire
